@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

@@ rtl/core/bpfs_pkg.sv @@
`default_nettype none

package bpfs_pkg;

    // Field widths
    localparam int ID_W     = 32;
    localparam int ACCEL_W  = 2;
    localparam int COLOR_W  = 6;
    localparam int ALPHA_W  = 5;
    localparam int DEPTH_W  = 6;
    localparam int STENC_W  = 5;
    localparam int SAMPL_W  = 5;
    localparam int CMP_W    = 6;

    // APB register port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int CFG_IDX_W  = 3;

    // Register reset values
    localparam logic [COLOR_W-1:0] WANT_COLOR_RST   = COLOR_W'(24);
    localparam logic [ALPHA_W-1:0] WANT_ALPHA_RST   = '0;
    localparam logic [DEPTH_W-1:0] WANT_DEPTH_RST   = DEPTH_W'(16);
    localparam logic [STENC_W-1:0] WANT_STENCIL_RST = '0;
    localparam logic [SAMPL_W-1:0] WANT_SAMPLES_RST = '0;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WANT_COLOR   = 3'd0,
        CFG_WANT_ALPHA   = 3'd1,
        CFG_WANT_DEPTH   = 3'd2,
        CFG_WANT_STENCIL = 3'd3,
        CFG_WANT_SAMPLES = 3'd4
    } t_cfg_idx;

    // Attributes that take part in the ranking
    typedef struct packed {
        logic [ACCEL_W-1:0] accel;
        logic [COLOR_W-1:0] color;
        logic [ALPHA_W-1:0] alpha;
        logic [DEPTH_W-1:0] depth;
        logic [STENC_W-1:0] stencil;
        logic [SAMPL_W-1:0] samples;
    } t_fmt;

    // One registered candidate item
    typedef struct packed {
        logic [ID_W-1:0] id;
        t_fmt            fmt;
        logic            is_final;
    } t_cand;

    // True when count cand beats count cur against request req (cur != cand)
    function automatic logic count_beats(input logic [CMP_W-1:0] cur,
                                         input logic [CMP_W-1:0] cand,
                                         input logic [CMP_W-1:0] req);
        logic res;
        if (cur == req) begin
            res = 1'b0;
        end else if (cand == req) begin
            res = 1'b1;
        end else if (cur < req) begin
            res = (cand < req) ? (cur < cand) : 1'b1;
        end else begin
            res = (cand > req) ? (cur > cand) : 1'b0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/bpfs_ifs.sv @@
`default_nettype none

// Candidate format channel
interface bpfs_cand_if;
    logic                           valid;
    logic                           ready;
    logic [bpfs_pkg::ID_W-1:0]      format_id;
    logic [bpfs_pkg::ACCEL_W-1:0]   accel_level;
    logic [bpfs_pkg::COLOR_W-1:0]   color_count;
    logic [bpfs_pkg::ALPHA_W-1:0]   alpha_count;
    logic [bpfs_pkg::DEPTH_W-1:0]   depth_count;
    logic [bpfs_pkg::STENC_W-1:0]   stencil_count;
    logic [bpfs_pkg::SAMPL_W-1:0]   sample_count;
    logic                           is_final;

    modport source(output valid, format_id, accel_level, color_count, alpha_count,
                   depth_count, stencil_count, sample_count, is_final,
                   input ready);
    modport sink(input valid, format_id, accel_level, color_count, alpha_count,
                 depth_count, stencil_count, sample_count, is_final,
                 output ready);
endinterface

// Chosen format channel
interface bpfs_result_if;
    logic                      valid;
    logic                      ready;
    logic [bpfs_pkg::ID_W-1:0] chosen_id;

    modport source(output valid, chosen_id, input ready);
    modport sink(input valid, chosen_id, output ready);
endinterface

`default_nettype wire

@@ rtl/core/best_pixel_format_select.sv @@
// Path: a final item passes the input register, then the result register.
// Throughput: one item per cycle; only a final item waits, and only while the
// result register still holds an untaken result.
// Between them sits one compare against the registered best.
// Reset: synchronous, active low; clears the list and valid flags, loads register defaults.
`default_nettype none

module best_pixel_format_select (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    bpfs_cand_if.sink                              i_cand,
    bpfs_result_if.source                          o_result,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bpfs_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [bpfs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [bpfs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    // Requested counts
    logic [bpfs_pkg::COLOR_W-1:0] r_want_color;
    logic [bpfs_pkg::ALPHA_W-1:0] r_want_alpha;
    logic [bpfs_pkg::DEPTH_W-1:0] r_want_depth;
    logic [bpfs_pkg::STENC_W-1:0] r_want_stencil;
    logic [bpfs_pkg::SAMPL_W-1:0] r_want_samples;

    // Input stage
    logic                  r_in_valid;
    bpfs_pkg::t_cand       r_in;
    bpfs_pkg::t_cand       n_in;

    // Running best of the current list
    logic                          r_have_best;
    logic [bpfs_pkg::ID_W-1:0]     r_best_id;
    bpfs_pkg::t_fmt                r_best;

    // Result register
    logic                          r_out_valid;
    logic [bpfs_pkg::ID_W-1:0]     r_out_id;
    logic [bpfs_pkg::ID_W-1:0]     n_out_id;

    logic                          out_free;
    logic                          s1_fire;
    logic                          in_ready;
    logic                          cand_wins;
    logic                          take;
    logic                          cfg_wr;
    bpfs_pkg::t_cfg_idx            cfg_idx;

    // Handshake
    assign out_free = !r_out_valid || o_result.ready;
    assign s1_fire  = r_in_valid && (!r_in.is_final || out_free);
    assign in_ready = !r_in_valid || s1_fire;

    assign i_cand.ready      = in_ready;
    assign o_result.valid    = r_out_valid;
    assign o_result.chosen_id = r_out_id;

    assign n_in.id           = i_cand.format_id;
    assign n_in.fmt.accel    = i_cand.accel_level;
    assign n_in.fmt.color    = i_cand.color_count;
    assign n_in.fmt.alpha    = i_cand.alpha_count;
    assign n_in.fmt.depth    = i_cand.depth_count;
    assign n_in.fmt.stencil  = i_cand.stencil_count;
    assign n_in.fmt.samples  = i_cand.sample_count;
    assign n_in.is_final     = i_cand.is_final;

    // Ranking: accel first, then the first differing count decides
    always_comb begin
        if (r_best.accel != r_in.fmt.accel) begin
            cand_wins = r_best.accel < r_in.fmt.accel;
        end else if (r_best.color != r_in.fmt.color) begin
            cand_wins = bpfs_pkg::count_beats(r_best.color, r_in.fmt.color, r_want_color);
        end else if (r_best.alpha != r_in.fmt.alpha) begin
            cand_wins = bpfs_pkg::count_beats({1'b0, r_best.alpha},
                                              {1'b0, r_in.fmt.alpha},
                                              {1'b0, r_want_alpha});
        end else if (r_best.depth != r_in.fmt.depth) begin
            cand_wins = bpfs_pkg::count_beats(r_best.depth, r_in.fmt.depth, r_want_depth);
        end else if (r_best.stencil != r_in.fmt.stencil) begin
            cand_wins = bpfs_pkg::count_beats({1'b0, r_best.stencil},
                                              {1'b0, r_in.fmt.stencil},
                                              {1'b0, r_want_stencil});
        end else if (r_best.samples != r_in.fmt.samples) begin
            cand_wins = bpfs_pkg::count_beats({1'b0, r_best.samples},
                                              {1'b0, r_in.fmt.samples},
                                              {1'b0, r_want_samples});
        end else begin
            // full tie keeps the earlier format
            cand_wins = 1'b0;
        end
    end

    assign take     = !r_have_best || cand_wins;
    assign n_out_id = take ? r_in.id : r_best_id;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_cand.valid;
        end
        if (in_ready && i_cand.valid) begin
            r_in <= n_in;
        end
    end

    // Best tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_best <= 1'b0;
        end else if (s1_fire) begin
            r_have_best <= !r_in.is_final;
        end
        if (s1_fire && take) begin
            r_best_id <= r_in.id;
            r_best    <= r_in.fmt;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_in.is_final) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_fire && r_in.is_final) begin
            r_out_id <= n_out_id;
        end
    end

    // Register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = bpfs_pkg::t_cfg_idx'(paddr[bpfs_pkg::APB_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_want_color   <= bpfs_pkg::WANT_COLOR_RST;
            r_want_alpha   <= bpfs_pkg::WANT_ALPHA_RST;
            r_want_depth   <= bpfs_pkg::WANT_DEPTH_RST;
            r_want_stencil <= bpfs_pkg::WANT_STENCIL_RST;
            r_want_samples <= bpfs_pkg::WANT_SAMPLES_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                bpfs_pkg::CFG_WANT_COLOR: begin
                    r_want_color <= pwdata[bpfs_pkg::COLOR_W-1:0];
                end
                bpfs_pkg::CFG_WANT_ALPHA: begin
                    r_want_alpha <= pwdata[bpfs_pkg::ALPHA_W-1:0];
                end
                bpfs_pkg::CFG_WANT_DEPTH: begin
                    r_want_depth <= pwdata[bpfs_pkg::DEPTH_W-1:0];
                end
                bpfs_pkg::CFG_WANT_STENCIL: begin
                    r_want_stencil <= pwdata[bpfs_pkg::STENC_W-1:0];
                end
                bpfs_pkg::CFG_WANT_SAMPLES: begin
                    r_want_samples <= pwdata[bpfs_pkg::SAMPL_W-1:0];
                end
                default: begin
                    // unmapped address, write dropped
                end
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (cfg_idx)
            bpfs_pkg::CFG_WANT_COLOR:   prdata = bpfs_pkg::APB_DATA_W'(r_want_color);
            bpfs_pkg::CFG_WANT_ALPHA:   prdata = bpfs_pkg::APB_DATA_W'(r_want_alpha);
            bpfs_pkg::CFG_WANT_DEPTH:   prdata = bpfs_pkg::APB_DATA_W'(r_want_depth);
            bpfs_pkg::CFG_WANT_STENCIL: prdata = bpfs_pkg::APB_DATA_W'(r_want_stencil);
            bpfs_pkg::CFG_WANT_SAMPLES: prdata = bpfs_pkg::APB_DATA_W'(r_want_samples);
            default:                    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/bpfs_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module bpfs_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_ready,
    input wire logic                              i_out_valid,
    input wire logic                              i_out_ready,
    input wire logic [bpfs_pkg::ID_W-1:0]         i_chosen_id,
    input wire logic                              i_psel,
    input wire logic                              i_penable,
    input wire logic                              i_pwrite,
    input wire logic [bpfs_pkg::APB_ADDR_W-1:0]   i_paddr,
    input wire logic [bpfs_pkg::APB_DATA_W-1:0]   i_pwdata,
    input wire logic [bpfs_pkg::APB_DATA_W-1:0]   i_prdata
);

    logic wr_color;
    logic rd_color;

    assign wr_color = i_psel && i_penable && i_pwrite &&
                      (i_paddr[bpfs_pkg::APB_ADDR_W-1:2] == bpfs_pkg::CFG_WANT_COLOR);
    assign rd_color = i_psel && !i_pwrite &&
                      (i_paddr[bpfs_pkg::APB_ADDR_W-1:2] == bpfs_pkg::CFG_WANT_COLOR);

    // No result survives reset
    `ASSERT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n |=> !i_out_valid)

    // A stalled result holds its value
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_chosen_id))

    // With room at the output, the block always takes a new item
    `ASSERT_CLK(a_in_ready_free, i_clk, i_rst_n, !i_out_valid || i_out_ready |-> i_in_ready)

    // A color request write reads back masked to its field width
    `ASSERT_CLK(a_cfg_readback, i_clk, i_rst_n,
        wr_color |=> !rd_color ||
            (i_prdata == bpfs_pkg::APB_DATA_W'($past(i_pwdata[bpfs_pkg::COLOR_W-1:0]))))

endmodule

bind best_pixel_format_select bpfs_checker u_bpfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_cand.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_chosen_id (o_result.chosen_id),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata)
);

`default_nettype wire
